// ===== rtl/core/skh_pkg.sv =====
// Shared types, constants and round functions for the keyed SHA-256 block.
`timescale 1ns / 1ps
`default_nettype none

package skh_pkg;

  localparam int NumRounds = 64;
  localparam int RoundW    = $clog2(NumRounds);
  localparam int WordW     = 32;
  localparam int NumSecret = 4;
  localparam int CfgAddrW  = $clog2(NumSecret) + 3;
  localparam int MsgWords  = 4;
  localparam int DigWords  = 8;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic              load;
    logic              round_en;
    logic              out_load;
    logic [RoundW-1:0] round_idx;
  } skh_cmd_t;

  localparam word_t PadWord = 32'h8000_0000;
  localparam word_t LenWord = 32'h0000_0180;

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [DigWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/skh_ctrl.sv =====
// Controller: handshakes, round counter and sequencing of the datapath.
`timescale 1ns / 1ps
`default_nettype none

module skh_ctrl
  import skh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output skh_cmd_t  cmd
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StFinal = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [RoundW-1:0] cnt_r, cnt_nxt;
  logic              oval_r, oval_nxt;
  logic              out_free;

  assign out_free      = !oval_r || out_tready;
  assign in_tready     = (state_r == StIdle);
  assign out_tvalid    = oval_r;
  assign cmd.load      = in_tvalid && in_tready;
  assign cmd.round_en  = (state_r == StRound);
  assign cmd.out_load  = (state_r == StFinal) && out_free;
  assign cmd.round_idx = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      StIdle: begin
        if (cmd.load) begin
          state_nxt = StRound;
          cnt_nxt   = '0;
        end
      end
      StRound: begin
        cnt_nxt = cnt_r + RoundW'(1);
        if (cnt_r == RoundW'(NumRounds - 1)) begin
          state_nxt = StFinal;
        end
      end
      StFinal: begin
        if (out_free) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (cmd.out_load) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/skh_datapath.sv =====
// Datapath: message schedule window, working variables, round logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module skh_datapath
  import skh_pkg::*;
(
  input  wire logic                         clk,
  input  wire skh_cmd_t                     cmd,
  input  wire word_t [DigWords-1:0]         secret,
  input  wire logic [MsgWords*WordW-1:0]    msg,
  output logic [DigWords*WordW-1:0]         digest
);

  word_t [15:0]                w_r, w_nxt;
  word_t [DigWords-1:0]        v_r, v_nxt;
  logic [DigWords*WordW-1:0]   out_r, out_nxt;
  word_t                       w_new, ch, maj, t1, t2;

  assign digest = out_r;

  always_comb begin
    w_new = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + big_sigma1(v_r[4]) + ch + w_r[0] + RoundK[cmd.round_idx];
    t2    = big_sigma0(v_r[0]) + maj;
  end

  always_comb begin
    w_nxt   = w_r;
    v_nxt   = v_r;
    out_nxt = out_r;
    if (cmd.load) begin
      for (int i = 0; i < DigWords; i++) begin
        w_nxt[i] = secret[i];
        v_nxt[i] = InitHash[i];
      end
      for (int i = 0; i < MsgWords; i++) begin
        w_nxt[DigWords+i] = msg[i*WordW +: WordW];
      end
      w_nxt[12] = PadWord;
      w_nxt[13] = '0;
      w_nxt[14] = '0;
      w_nxt[15] = LenWord;
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = w_new;
      v_nxt[7]  = v_r[6];
      v_nxt[6]  = v_r[5];
      v_nxt[5]  = v_r[4];
      v_nxt[4]  = v_r[3] + t1;
      v_nxt[3]  = v_r[2];
      v_nxt[2]  = v_r[1];
      v_nxt[1]  = v_r[0];
      v_nxt[0]  = t1 + t2;
    end
    if (cmd.out_load) begin
      for (int i = 0; i < DigWords; i++) begin
        out_nxt[i*WordW +: WordW] = v_r[i] + InitHash[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    v_r   <= v_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_fixed_block_keyed_hash_top.sv =====
// Top level: keyed SHA-256 over one fixed block, with secret registers on an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

// Each input word carries a 128-bit message; the block hashes one 512-bit block made of the
// 256-bit secret (registers at byte addresses 0, 8, 16, 24, word 2i in the upper half), the
// message, the standard padding and a bit length of 384, and returns the eight digest words.
// One round runs per cycle in a single round unit. A word passes through the load, 64 rounds and
// the final add, and no new word is taken before the previous one has finished. A finished
// result waits in the output register, and the next word is accepted meanwhile; only the final
// add waits for that register to free up. Write the secret only while the block is idle.
module sha256_fixed_block_keyed_hash_top
  import skh_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // message_word_0 .. message_word_3, 32 bits each, from bit 0 up
  input  wire logic [127:0]        in_tdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // digest_word_0 .. digest_word_7, 32 bits each, from bit 0 up
  output logic [255:0]             out_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [63:0]         cfg_pwdata,
  output logic [63:0]              cfg_prdata,
  output logic                     cfg_pready
);

  logic [63:0]          secret_r [NumSecret];
  word_t [DigWords-1:0] secret_w;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  skh_cmd_t             cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CfgAddrW-1:3];
  assign cfg_prdata = secret_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumSecret; i++) begin
        secret_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      secret_r[cfg_idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < NumSecret; i++) begin
      secret_w[2*i]   = secret_r[i][63:32];
      secret_w[2*i+1] = secret_r[i][31:0];
    end
  end

  skh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  skh_datapath u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .secret (secret_w),
    .msg    (in_tdata),
    .digest (out_tdata)
  );

  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready while a word is in flight");

  // with the output register empty, the result shows up after a fixed latency
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##66 out_tvalid)
    else $error("result missing after 66 cycles");

  // the schedule load never coincides with the round update or the output update
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.round_en && !cmd.out_load)
    else $error("load overlaps round or output update");

endmodule

`default_nettype wire
